// File: src/fourier_series_epicycle_sum_assert.svh
// Assertion macros for the epicycle sum block.
// Needs clk and rst_n in the scope of each use.
`ifndef FOURIER_SERIES_EPICYCLE_SUM_ASSERT_SVH
`define FOURIER_SERIES_EPICYCLE_SUM_ASSERT_SVH

// Check that expr holds at every edge out of reset.
`define FSE_ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("fse: check failed");

// Check that cons holds in the cycle after ante.
`define FSE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fse: sequence check failed");

`endif

// File: src/fse_pkg.sv
// Shared widths, register codes, trig constants and the coefficient builder
// for the epicycle sum block. No dependencies.
package fse_pkg;

    localparam int MAX_TERMS_DEF = 64;

    localparam int KIND_W     = 2;
    localparam int WAVE_KINDS = 4;
    localparam int COUNT_W    = 7;
    localparam int CENTER_W   = 10;
    localparam int PHASE_W    = 16;
    localparam int FRAC_W     = 8;
    localparam int PEN_W      = 20;
    localparam int ACC_W      = 25;
    localparam int RAD_W      = 16;
    localparam int TRIG_W     = 17;
    localparam int FOLD_W     = 15;
    localparam int MUL_W      = 31;
    localparam int PROD_W     = 62;
    localparam int REG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_WAVE_KIND  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TERM_COUNT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_X   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y   = 2'd3;

    // Wave kinds
    localparam logic [KIND_W-1:0] WAVE_SQUARE   = 2'd0;
    localparam logic [KIND_W-1:0] WAVE_SAWTOOTH = 2'd1;
    localparam logic [KIND_W-1:0] WAVE_TRIANGLE = 2'd2;
    localparam logic [KIND_W-1:0] WAVE_CUBIC    = 2'd3;

    localparam logic [KIND_W-1:0]   WAVE_KIND_RST  = WAVE_SQUARE;
    localparam logic [COUNT_W-1:0]  TERM_COUNT_RST = 7'd1;
    localparam logic [CENTER_W-1:0] CENTER_X_RST   = 10'd150;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST   = 10'd240;

    localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [FOLD_W-1:0]  FOLD_TOP     = 15'd16384;

    // Odd sine polynomial in Q30
    localparam logic [MUL_W-1:0] TRIG_A1 = 31'd1686629713;
    localparam logic [MUL_W-1:0] TRIG_A3 = 31'd693598668;
    localparam logic [MUL_W-1:0] TRIG_A5 = 31'd85569304;
    localparam logic [MUL_W-1:0] TRIG_A7 = 31'd5026995;
    localparam logic [MUL_W-1:0] TRIG_A9 = 31'd172272;

    localparam logic signed [ACC_W-1:0] PEN_MAX = 25'sd524287;
    localparam logic signed [ACC_W-1:0] PEN_MIN = -25'sd524288;

    localparam longint unsigned PI_NUM = 64'd355;
    localparam longint unsigned PI_DEN = 64'd113;

    typedef struct packed {
        logic             neg;
        logic [RAD_W-1:0] mag;
    } coef_t;

    // Shift-subtract division, evaluated at elaboration only
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Signed Q.8 radius of term idx, rounded to nearest with ties up
    function automatic coef_t coef_entry(input int kind, input int idx);
        longint unsigned ii;
        longint unsigned n;
        longint unsigned num;
        longint unsigned den;
        longint unsigned mag;
        logic            neg;
        coef_t           c;
        ii  = longint'(idx);
        neg = 1'b0;
        case (kind)
            0:
            begin
                n   = 2 * ii + 1;
                num = 280 * PI_DEN * 256;
                den = PI_NUM * n;
            end
            1:
            begin
                n   = ii + 1;
                num = 140 * PI_DEN * 256;
                den = PI_NUM * n;
                neg = n[0];
            end
            2:
            begin
                n   = 2 * ii + 1;
                num = 560 * PI_DEN * PI_DEN * 256;
                den = PI_NUM * PI_NUM * n * n;
                neg = ~ii[0];
            end
            default:
            begin
                n   = ii + 1;
                num = 10 * (n * n * PI_NUM * PI_NUM - 6 * PI_DEN * PI_DEN) * 256;
                den = PI_DEN * PI_DEN * n * n * n;
                neg = n[0];
            end
        endcase
        mag   = udiv64(2 * num + den, 2 * den);
        c.neg = neg;
        c.mag = mag[RAD_W-1:0];
        return c;
    endfunction

    function automatic logic signed [PEN_W-1:0] sat_pen(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        if (v > PEN_MAX)
            s = PEN_MAX;
        else if (v < PEN_MIN)
            s = PEN_MIN;
        else
            s = v;
        return s[PEN_W-1:0];
    endfunction

endpackage

// File: src/fse_coef_rom.sv
// Build-time radius table, one row per wave kind, registered read.
// Depends on fse_pkg (coef_t, coef_entry).
module fse_coef_rom #(
    parameter int MAX_TERMS = fse_pkg::MAX_TERMS_DEF,
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
    input  logic                        clk,
    input  logic [fse_pkg::KIND_W-1:0]  kind,
    input  logic [IDX_W-1:0]            idx,
    output fse_pkg::coef_t              coef
);

    fse_pkg::coef_t tab [fse_pkg::WAVE_KINDS][MAX_TERMS];

    for (genvar gk = 0; gk < fse_pkg::WAVE_KINDS; gk++)
    begin : g_kind
        for (genvar gi = 0; gi < MAX_TERMS; gi++)
        begin : g_term
            localparam fse_pkg::coef_t ENT = fse_pkg::coef_entry(gk, gi);
            assign tab[gk][gi] = ENT;
        end
    end

    always_ff @(posedge clk)
    begin
        coef <= tab[kind][idx];
    end

endmodule

// File: src/fourier_series_epicycle_sum.sv
// Epicycle pen: one 31x31 multiplier runs 14 products per term (sin and cos
// polynomials interleaved, then two radius products), then an accumulate step.
// It sums N = min(term_count, MAX_TERMS) terms per request. Requests do not
// overlap: in_stall is high from the accepted request until the result is
// registered, and a result waits while out_stall holds the previous one.
// Reset: asynchronous, control and config registers back to their defaults, phase cleared.
`include "fourier_series_epicycle_sum_assert.svh"

module fourier_series_epicycle_sum #(
    parameter int MAX_TERMS = fse_pkg::MAX_TERMS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fse_pkg::REG_IDX_W-1:0]        cfg_index,
    input  logic [fse_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [fse_pkg::PHASE_W-1:0]          phase_step,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [fse_pkg::PEN_W-1:0]     pen_x,
    output logic signed [fse_pkg::PEN_W-1:0]     pen_y
);

    localparam int TC_W  = $clog2(MAX_TERMS + 1);
    localparam int LIM_W = (TC_W > fse_pkg::COUNT_W) ? TC_W : fse_pkg::COUNT_W;
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

    // Steps of a term; each step but ST_ACC issues one product to the multiplier
    typedef enum logic [3:0] {
        ST_SQ_S, ST_SQ_C, ST_A9_S, ST_A9_C, ST_P7_S, ST_P7_C, ST_P5_S, ST_P5_C,
        ST_P3_S, ST_P3_C, ST_P1_S, ST_P1_C, ST_RAD_S, ST_RAD_C, ST_ACC
    } step_t;

    // Control and configuration
    state_t                              state_reg, state_next;
    step_t                               step_reg, step_next;
    logic [LIM_W-1:0]                    tcnt_reg, tcnt_next;
    logic [LIM_W-1:0]                    limit_reg, limit_next;
    logic [fse_pkg::PHASE_W-1:0]         phase_acc_reg, phase_acc_next;
    logic                                out_valid_reg, out_valid_next;
    logic signed [fse_pkg::PEN_W-1:0]    pen_x_reg, pen_x_next;
    logic signed [fse_pkg::PEN_W-1:0]    pen_y_reg, pen_y_next;
    logic [fse_pkg::KIND_W-1:0]          wave_kind_reg, wave_kind_next;
    logic [fse_pkg::COUNT_W-1:0]         term_count_reg, term_count_next;
    logic [fse_pkg::CENTER_W-1:0]        center_x_reg, center_x_next;
    logic [fse_pkg::CENTER_W-1:0]        center_y_reg, center_y_next;

    // Datapath
    logic [fse_pkg::PHASE_W-1:0]         ang_reg, ang_next;
    logic [fse_pkg::MUL_W-1:0]           z2s_reg, z2s_next, z2c_reg, z2c_next;
    logic [fse_pkg::MUL_W-1:0]           ps_reg, ps_next, pc_reg, pc_next;
    logic [fse_pkg::TRIG_W-1:0]          ms_reg, ms_next, mc_reg, mc_next;
    logic signed [fse_pkg::ACC_W-1:0]    x_acc_reg, x_acc_next, y_acc_reg, y_acc_next;
    logic [fse_pkg::PROD_W-1:0]          prod_reg, prod_next;

    logic                                in_accept;
    logic                                out_take;
    logic [fse_pkg::PHASE_W-1:0]         phase_sum;
    logic [LIM_W-1:0]                    limit_in;
    logic [LIM_W-1:0]                    tcnt_inc;
    logic                                odd_harm;
    logic [fse_pkg::PHASE_W-1:0]         ang_delta;
    logic [fse_pkg::PHASE_W-1:0]         ang_cos;
    logic [fse_pkg::FOLD_W-1:0]          rs, rc;
    logic                                sin_neg, cos_neg;
    logic [fse_pkg::MUL_W-1:0]           mul_a, mul_b;
    logic [fse_pkg::MUL_W-1:0]           p_coef, p_new;
    logic [fse_pkg::TRIG_W:0]            trig_sum;
    logic [fse_pkg::TRIG_W:0]            term_sum;
    logic signed [fse_pkg::TRIG_W+1:0]   term_pos, term_val;
    logic                                term_neg;
    logic signed [fse_pkg::ACC_W-1:0]    x_init, y_init;
    fse_pkg::coef_t                      coef;

    fse_coef_rom #(
        .MAX_TERMS (MAX_TERMS)
    ) u_coef_rom (
        .clk  (clk),
        .kind (wave_kind_reg),
        .idx  (tcnt_reg[IDX_W-1:0]),
        .coef (coef)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign pen_x     = pen_x_reg;
    assign pen_y     = pen_y_reg;

    assign phase_sum = phase_acc_reg + phase_step;
    assign limit_in  = (LIM_W'(term_count_reg) > LIM_W'(MAX_TERMS)) ?
                       LIM_W'(MAX_TERMS) : LIM_W'(term_count_reg);
    assign tcnt_inc  = tcnt_reg + 1'b1;

    // Square and triangle use odd harmonics only
    assign odd_harm  = (wave_kind_reg == fse_pkg::WAVE_SQUARE) ||
                       (wave_kind_reg == fse_pkg::WAVE_TRIANGLE);
    assign ang_delta = odd_harm ? {phase_acc_reg[fse_pkg::PHASE_W-2:0], 1'b0} : phase_acc_reg;

    // Fold both angles into the first quadrant
    assign ang_cos = ang_reg + fse_pkg::QUARTER_TURN;
    assign rs      = ang_reg[14] ? (fse_pkg::FOLD_TOP - {1'b0, ang_reg[13:0]})
                                 : {1'b0, ang_reg[13:0]};
    assign rc      = ang_cos[14] ? (fse_pkg::FOLD_TOP - {1'b0, ang_cos[13:0]})
                                 : {1'b0, ang_cos[13:0]};
    assign sin_neg = ang_reg[15];
    assign cos_neg = ang_cos[15];

    assign x_init = fse_pkg::ACC_W'(signed'({1'b0, center_x_reg, {fse_pkg::FRAC_W{1'b0}}}));
    assign y_init = fse_pkg::ACC_W'(signed'({1'b0, center_y_reg, {fse_pkg::FRAC_W{1'b0}}}));

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (step_reg) inside
            ST_SQ_S:
            begin
                mul_a = fse_pkg::MUL_W'(rs);
                mul_b = fse_pkg::MUL_W'(rs);
            end
            ST_SQ_C:
            begin
                mul_a = fse_pkg::MUL_W'(rc);
                mul_b = fse_pkg::MUL_W'(rc);
            end
            ST_A9_S:
            begin
                mul_a = fse_pkg::TRIG_A9;
                mul_b = z2s_reg;
            end
            ST_A9_C:
            begin
                mul_a = fse_pkg::TRIG_A9;
                mul_b = z2c_reg;
            end
            ST_P7_S, ST_P5_S, ST_P3_S:
            begin
                mul_a = ps_reg;
                mul_b = z2s_reg;
            end
            ST_P7_C, ST_P5_C, ST_P3_C:
            begin
                mul_a = pc_reg;
                mul_b = z2c_reg;
            end
            ST_P1_S:
            begin
                mul_a = ps_reg;
                mul_b = fse_pkg::MUL_W'(rs);
            end
            ST_P1_C:
            begin
                mul_a = pc_reg;
                mul_b = fse_pkg::MUL_W'(rc);
            end
            ST_RAD_S:
            begin
                mul_a = fse_pkg::MUL_W'(coef.mag);
                mul_b = fse_pkg::MUL_W'(ms_reg);
            end
            ST_RAD_C:
            begin
                mul_a = fse_pkg::MUL_W'(coef.mag);
                mul_b = fse_pkg::MUL_W'(mc_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Horner coefficient for the product that lands in this step
    always_comb
    begin
        case (step_reg) inside
            ST_A9_C, ST_P7_S: p_coef = fse_pkg::TRIG_A7;
            ST_P7_C, ST_P5_S: p_coef = fse_pkg::TRIG_A5;
            ST_P5_C, ST_P3_S: p_coef = fse_pkg::TRIG_A3;
            default:          p_coef = fse_pkg::TRIG_A1;
        endcase
    end

    assign p_new    = p_coef - prod_reg[60:30];
    assign trig_sum = {1'b0, prod_reg[44:28]} + {{fse_pkg::TRIG_W{1'b0}}, prod_reg[27]};
    assign term_sum = {1'b0, prod_reg[32:16]} + {{fse_pkg::TRIG_W{1'b0}}, prod_reg[15]};
    assign term_pos = signed'({1'b0, term_sum});
    assign term_neg = coef.neg ^ ((step_reg == ST_ACC) ? cos_neg : sin_neg);
    assign term_val = term_neg ? -term_pos : term_pos;

    always_comb
    begin
        ang_next   = ang_reg;
        z2s_next   = z2s_reg;
        z2c_next   = z2c_reg;
        ps_next    = ps_reg;
        pc_next    = pc_reg;
        ms_next    = ms_reg;
        mc_next    = mc_reg;
        x_acc_next = x_acc_reg;
        y_acc_next = y_acc_reg;
        prod_next  = {{fse_pkg::MUL_W{1'b0}}, mul_a} * {{fse_pkg::MUL_W{1'b0}}, mul_b};
        if (in_accept)
        begin
            ang_next   = phase_sum;
            x_acc_next = x_init;
            y_acc_next = y_init;
        end
        else if (state_reg == S_RUN)
        begin
            case (step_reg) inside
                ST_SQ_C:  z2s_next = {prod_reg[28:0], 2'b00};
                ST_A9_S:  z2c_next = {prod_reg[28:0], 2'b00};
                ST_A9_C, ST_P7_C, ST_P5_C, ST_P3_C:
                          ps_next = p_new;
                ST_P7_S, ST_P5_S, ST_P3_S, ST_P1_S:
                          pc_next = p_new;
                ST_P1_C:  ms_next = trig_sum[fse_pkg::TRIG_W-1:0];
                ST_RAD_S: mc_next = trig_sum[fse_pkg::TRIG_W-1:0];
                ST_RAD_C: y_acc_next = y_acc_reg + fse_pkg::ACC_W'(term_val);
                ST_ACC:
                begin
                    x_acc_next = x_acc_reg + fse_pkg::ACC_W'(term_val);
                    // advance to the next harmonic
                    ang_next   = ang_reg + ang_delta;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        tcnt_next       = tcnt_reg;
        limit_next      = limit_reg;
        phase_acc_next  = phase_acc_reg;
        out_valid_next  = out_valid_reg;
        pen_x_next      = pen_x_reg;
        pen_y_next      = pen_y_reg;
        wave_kind_next  = wave_kind_reg;
        term_count_next = term_count_reg;
        center_x_next   = center_x_reg;
        center_y_next   = center_y_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                fse_pkg::REG_WAVE_KIND:  wave_kind_next  = cfg_data[fse_pkg::KIND_W-1:0];
                fse_pkg::REG_TERM_COUNT: term_count_next = cfg_data[fse_pkg::COUNT_W-1:0];
                fse_pkg::REG_CENTER_X:   center_x_next   = cfg_data;
                fse_pkg::REG_CENTER_Y:   center_y_next   = cfg_data;
                default:
                begin
                end
            endcase
        end

        if (out_take)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    phase_acc_next = phase_sum;
                    limit_next     = limit_in;
                    tcnt_next      = '0;
                    step_next      = ST_SQ_S;
                    state_next     = (limit_in == '0) ? S_DONE : S_RUN;
                end
            end
            S_RUN:
            begin
                if (step_reg == ST_ACC)
                begin
                    step_next = ST_SQ_S;
                    tcnt_next = tcnt_inc;
                    if (tcnt_inc == limit_reg)
                        state_next = S_DONE;
                end
                else
                begin
                    step_next = step_t'(step_reg + 4'd1);
                end
            end
            S_DONE:
            begin
                // hold until the output slot is free
                if (!out_valid_reg || !out_stall)
                begin
                    pen_x_next     = fse_pkg::sat_pen(x_acc_reg);
                    pen_y_next     = fse_pkg::sat_pen(y_acc_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= ST_SQ_S;
            tcnt_reg       <= '0;
            limit_reg      <= '0;
            phase_acc_reg  <= '0;
            out_valid_reg  <= 1'b0;
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            wave_kind_reg  <= fse_pkg::WAVE_KIND_RST;
            term_count_reg <= fse_pkg::TERM_COUNT_RST;
            center_x_reg   <= fse_pkg::CENTER_X_RST;
            center_y_reg   <= fse_pkg::CENTER_Y_RST;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            tcnt_reg       <= tcnt_next;
            limit_reg      <= limit_next;
            phase_acc_reg  <= phase_acc_next;
            out_valid_reg  <= out_valid_next;
            pen_x_reg      <= pen_x_next;
            pen_y_reg      <= pen_y_next;
            wave_kind_reg  <= wave_kind_next;
            term_count_reg <= term_count_next;
            center_x_reg   <= center_x_next;
            center_y_reg   <= center_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ang_reg   <= ang_next;
        z2s_reg   <= z2s_next;
        z2c_reg   <= z2c_next;
        ps_reg    <= ps_next;
        pc_reg    <= pc_next;
        ms_reg    <= ms_next;
        mc_reg    <= mc_next;
        x_acc_reg <= x_acc_next;
        y_acc_reg <= y_acc_next;
        prod_reg  <= prod_next;
    end

    `FSE_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall, in_stall)
    `FSE_ASSERT_ALWAYS(a_term_in_range, (state_reg != S_RUN) || (tcnt_reg < limit_reg))
    `FSE_ASSERT_NEXT(a_term_restart, (state_reg == S_RUN) && (step_reg == ST_ACC), step_reg == ST_SQ_S)
    `FSE_ASSERT_NEXT(a_hold_result, (state_reg == S_DONE) && out_valid && out_stall, state_reg == S_DONE)

endmodule
